@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros included by the encoder unit.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/fsk_pte_pkg.sv @@
// ---------------------------------------------------------------------------
// FSK packet tone encoder package
// Register codes, packet constants, the CRC byte step and the sine entry
// generator used to fill the tone table at elaboration.
// ---------------------------------------------------------------------------
package fsk_pte_pkg;

  localparam int unsigned CFG_WIDTH   = 32;
  localparam int unsigned INDEX_WIDTH = 3;

  typedef enum logic [INDEX_WIDTH-1:0] {
    REG_MARK_INC  = 3'd0,
    REG_SPACE_INC = 3'd1,
    REG_AMPLITUDE = 3'd2,
    REG_SPB       = 3'd3,
    REG_OPCODE    = 3'd4,
    REG_ARGUMENT  = 3'd5,
    REG_UNIT      = 3'd6
  } reg_index_t;

  localparam logic [15:0] SYNC_WORD     = 16'h07FF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [14:0] AMP_RESET     = 15'd16384;
  localparam logic [7:0]  SPB_RESET     = 8'd7;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // One byte of CRC-CCITT, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Quarter-wave sine in Q15 from a Taylor series to x^13 in Q30.
  function automatic logic signed [15:0] quarter_sine(input int unsigned m,
                                                       input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    x    = (longint'(m) * TWO_PI_Q30) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    term = ((term * x2) >> 30) / 6;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 20;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 42;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 72;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 110;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 156;
    s    = s + longint'(term);
    if (s < 0) begin
      s = 0;
    end
    s = (s * 32767 + (longint'(1) << 29)) >>> 30;
    if (s > 32767) begin
      s = 32767;
    end
    return 16'(s);
  endfunction

  // Full-wave table entry built from quarter-wave symmetry.
  function automatic logic signed [15:0] sine_entry(input int unsigned idx,
                                                     input int unsigned bits);
    int unsigned     quarter;
    int unsigned     q;
    int unsigned     r;
    logic signed [15:0] v;
    quarter = 1 << (bits - 2);
    q       = idx >> (bits - 2);
    r       = idx & (quarter - 1);
    v       = q[0] ? quarter_sine(quarter - r, bits) : quarter_sine(r, bits);
    return q[1] ? -v : v;
  endfunction

endpackage

@@ rtl/fsk_pte_in_if.sv @@
// ---------------------------------------------------------------------------
// Input channel
// Carries one audio sample word and its restart flag.
// ---------------------------------------------------------------------------
interface fsk_pte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic               restart;

  modport source (output valid, output sample_in, output restart, input ready);
  modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

@@ rtl/fsk_pte_out_if.sv @@
// ---------------------------------------------------------------------------
// Output channel
// Carries one mixed sample word and the packet done flag.
// ---------------------------------------------------------------------------
interface fsk_pte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               done_res;

  modport source (output valid, output sample_out, output done_res, input ready);
  modport sink   (input valid, input sample_out, input done_res, output ready);
endinterface

@@ rtl/fsk_pte_crc.sv @@
// ---------------------------------------------------------------------------
// Packet CRC pipeline
// Computes the CRC-CCITT of the four latched packet bytes, one byte per stage.
// ---------------------------------------------------------------------------
module fsk_pte_crc
  import fsk_pte_pkg::*;
(
  input  logic        clk,
  input  logic [7:0]  opcode,
  input  logic [7:0]  argument,
  input  logic [15:0] unit,
  output logic [15:0] crc
);

  logic [15:0] crc_op;
  logic [15:0] crc_arg;
  logic [15:0] crc_hi;

  // The result passes through crc_op, crc_arg, crc_hi and crc and settles long
  // before the CRC field is reached in the bit stream.
  always_ff @(posedge clk) begin
    crc_op  <= crc_byte(CRC_INIT, opcode);
    crc_arg <= crc_byte(crc_op, argument);
    crc_hi  <= crc_byte(crc_arg, unit[15:8]);
    crc     <= crc_byte(crc_hi, unit[7:0]);
  end

endmodule

@@ rtl/fsk_pte_sine_rom.sv @@
// ---------------------------------------------------------------------------
// Sine table
// Full-wave Q15 sine ROM filled at elaboration, with a registered read.
// ---------------------------------------------------------------------------
module fsk_pte_sine_rom
  import fsk_pte_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [INDEX_BITS-1:0]  rd_addr,
  output logic signed [15:0]     rd_data
);

  localparam int unsigned DEPTH = 1 << INDEX_BITS;

  logic signed [15:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_fill
    assign rom[i] = sine_entry(i, INDEX_BITS);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom[rd_addr];
    end
  end

endmodule

@@ rtl/fsk_pte_mix.sv @@
// ---------------------------------------------------------------------------
// Tone mixer
// Scales the sine value by the amplitude and adds it to the audio sample
// with 16-bit saturation, or passes the sample through while inactive.
// ---------------------------------------------------------------------------
module fsk_pte_mix (
  input  logic signed [15:0] sine,
  input  logic [14:0]        amplitude,
  input  logic signed [15:0] sample,
  input  logic               active,
  output logic signed [15:0] mixed
);

  logic signed [31:0] product;
  logic signed [16:0] tone;
  logic signed [17:0] sum;

  always_comb begin
    product = sine * $signed({1'b0, amplitude});
    // An arithmetic shift floors, which matches rounding the magnitude up
    // for negative products.
    tone    = product[31:15];
    sum     = 18'(sample) + 18'(tone);
    if (!active) begin
      mixed = sample;
    end else if (sum > 18'sd32767) begin
      mixed = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      mixed = 16'sh8000;
    end else begin
      mixed = sum[15:0];
    end
  end

endmodule

@@ rtl/fsk_packet_tone_encoder_unit.sv @@
// An accepted word is registered in the s1 stage together with the sine table read,
// then mixed and registered in the output register. Throughput: one word per cycle
// unless the output stalls on mixed.ready; phase, bit and count update with the read.
// Reset (synchronous, rst high): registers take their reset values, the encoder
// is idle with done set and passes samples through until a restart word arrives.
// ---------------------------------------------------------------------------
// FSK packet tone encoder
// Sends a preamble, sync word, data bytes and CRC as two-tone FSK added to audio.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fsk_packet_tone_encoder_unit
  import fsk_pte_pkg::*;
#(
  parameter int unsigned PREAMBLE_LENGTH = 24,
  parameter int unsigned SINE_INDEX_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  fsk_pte_in_if.sink             audio,
  fsk_pte_out_if.source          mixed,
  input  logic                   write_en,
  input  logic [INDEX_WIDTH-1:0] reg_index,
  input  logic [CFG_WIDTH-1:0]   write_data
);

  localparam logic [6:0] PREAMBLE_BITS = 7'(PREAMBLE_LENGTH);
  localparam logic [6:0] PACKET_BITS   = 7'(PREAMBLE_LENGTH + 64);

  // Configuration registers.
  logic [31:0] mark_increment;
  logic [31:0] space_increment;
  logic [14:0] tone_amplitude;
  logic [7:0]  samples_per_bit;
  logic [7:0]  opcode_byte;
  logic [7:0]  argument_byte;
  logic [15:0] unit_ident;

  // Encoder state.
  logic [31:0] tone_phase;
  logic [6:0]  bit_index;
  logic [7:0]  sample_count;
  logic        finished;
  logic [7:0]  pkt_op;
  logic [7:0]  pkt_arg;
  logic [15:0] pkt_unit;
  logic [15:0] packet_crc;

  logic [31:0] tone_phase_next;
  logic [6:0]  bit_index_next;
  logic [7:0]  sample_count_next;
  logic        finished_next;

  logic [31:0] cur_phase;
  logic [6:0]  cur_bit;
  logic [7:0]  cur_count;
  logic        cur_finished;
  logic [63:0] pkt_word;
  logic [6:0]  data_pos;
  logic        tx_bit;
  logic [7:0]  count_inc;
  logic [6:0]  bit_inc;

  // Pipeline registers.
  logic               s1_valid;
  logic signed [15:0] s1_sample;
  logic               s1_active;
  logic               s1_done;
  logic signed [15:0] sine_value;
  logic signed [15:0] mix_value;
  logic               out_valid;
  logic signed [15:0] out_sample;
  logic               out_done;

  logic in_accept;
  logic out_load;

  assign out_load    = s1_valid && (!out_valid || mixed.ready);
  assign audio.ready = !s1_valid || out_load;
  assign in_accept   = audio.valid && audio.ready;

  assign mixed.valid      = out_valid;
  assign mixed.sample_out = out_sample;
  assign mixed.done_res   = out_done;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_increment  <= '0;
      space_increment <= '0;
      tone_amplitude  <= AMP_RESET;
      samples_per_bit <= SPB_RESET;
      opcode_byte     <= '0;
      argument_byte   <= '0;
      unit_ident      <= '0;
    end else if (write_en) begin
      unique case (reg_index)
        REG_MARK_INC:  mark_increment  <= write_data;
        REG_SPACE_INC: space_increment <= write_data;
        REG_AMPLITUDE: tone_amplitude  <= write_data[14:0];
        REG_SPB:       samples_per_bit <= write_data[7:0];
        REG_OPCODE:    opcode_byte     <= write_data[7:0];
        REG_ARGUMENT:  argument_byte   <= write_data[7:0];
        REG_UNIT:      unit_ident      <= write_data[15:0];
        default: ;
      endcase
    end
  end

  fsk_pte_crc u_crc (
    .clk      (clk),
    .opcode   (pkt_op),
    .argument (pkt_arg),
    .unit     (pkt_unit),
    .crc      (packet_crc)
  );

  // Bit selection and state update for the accepted word.
  always_comb begin
    cur_phase    = audio.restart ? '0 : tone_phase;
    cur_bit      = audio.restart ? '0 : bit_index;
    cur_count    = audio.restart ? '0 : sample_count;
    cur_finished = audio.restart ? 1'b0 : finished;

    pkt_word = {SYNC_WORD, pkt_op, pkt_arg, pkt_unit, packet_crc};
    data_pos = cur_bit - PREAMBLE_BITS;
    if (cur_bit < PREAMBLE_BITS) begin
      tx_bit = ~cur_bit[0];
    end else begin
      tx_bit = pkt_word[6'd63 - data_pos[5:0]];
    end

    count_inc = cur_count + 8'd1;
    bit_inc   = cur_bit + 7'd1;

    tone_phase_next   = cur_phase;
    bit_index_next    = cur_bit;
    sample_count_next = cur_count;
    finished_next     = cur_finished;
    if (!cur_finished) begin
      tone_phase_next = cur_phase + (tx_bit ? mark_increment : space_increment);
      if (count_inc >= samples_per_bit) begin
        sample_count_next = '0;
        bit_index_next    = bit_inc;
        finished_next     = (bit_inc >= PACKET_BITS);
      end else begin
        sample_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_phase   <= '0;
      bit_index    <= '0;
      sample_count <= '0;
      finished     <= 1'b1;
      pkt_op       <= '0;
      pkt_arg      <= '0;
      pkt_unit     <= '0;
    end else if (in_accept) begin
      tone_phase   <= tone_phase_next;
      bit_index    <= bit_index_next;
      sample_count <= sample_count_next;
      finished     <= finished_next;
      if (audio.restart) begin
        pkt_op   <= opcode_byte;
        pkt_arg  <= argument_byte;
        pkt_unit <= unit_ident;
      end
    end
  end

  fsk_pte_sine_rom #(
    .INDEX_BITS (SINE_INDEX_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (cur_phase[31 -: SINE_INDEX_BITS]),
    .rd_data (sine_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample <= audio.sample_in;
      s1_active <= !cur_finished;
      s1_done   <= finished_next;
    end
  end

  fsk_pte_mix u_mix (
    .sine      (sine_value),
    .amplitude (tone_amplitude),
    .sample    (s1_sample),
    .active    (s1_active),
    .mixed     (mix_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (mixed.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= mix_value;
      out_done   <= s1_done;
    end
  end

  // An idle encoder must not move its phase.
  `ASSERT_NEXT(a_idle_phase_holds, in_accept && finished && !audio.restart, tone_phase == $past(tone_phase))
  // A restart always leaves the encoder busy near the start of the packet.
  `ASSERT_NEXT(a_restart_starts, in_accept && audio.restart, !finished && bit_index <= 7'd1)
  // A staged word that cannot move on stays staged.
  `ASSERT_NEXT(a_stage_kept, s1_valid && !out_load, s1_valid)
  // The bit index never runs past the end of the packet.
  `ASSERT_IMPLIES(a_bit_bound, 1'b1, bit_index <= PACKET_BITS)

endmodule
